// ===== rtl/apsp_pkg.sv =====
`default_nettype none
package apsp_pkg;
  localparam int unsigned MaxVertices = 64;
  localparam int unsigned DistW = 24;
  localparam int unsigned WeightW = 16;
  localparam int unsigned VertW = 6;
  localparam int unsigned CountW = 7;
  localparam logic [DistW-1:0] DistInf = {DistW{1'b1}};

  typedef enum logic [1:0] {
    OpClear = 2'd0,
    OpAdd   = 2'd1,
    OpSolve = 2'd2,
    OpQuery = 2'd3
  } op_e;

  // saturating add, infinity absorbs
  function automatic logic [DistW-1:0] sat_add(input logic [DistW-1:0] a,
                                               input logic [DistW-1:0] b);
    logic [DistW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == DistInf || b == DistInf || s[DistW]) return DistInf;
    return s[DistW-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/apsp_cell.sv =====
`default_nettype none
// One column j of the matrix: holds dist/hop for every row i in column j.
// Relaxes d[i][j] against d[i][k] + d[k][j]; d[k][j] is latched once per pivot.
module apsp_cell
  import apsp_pkg::*;
#(
  parameter int unsigned NumV = MaxVertices,
  parameter int unsigned Col = 0
) (
  input  wire logic                     clk_i,
  input  wire logic                     clr_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(NumV)-1:0]  wr_row_i,
  input  wire logic [DistW-1:0]         wr_dist_i,
  input  wire logic                     kj_load_i,
  input  wire logic                     relax_i,
  input  wire logic [DistW-1:0]         dik_i,
  input  wire logic [VertW:0]           hik_i,
  input  wire logic [$clog2(NumV)-1:0]  rd_row_i,
  output      logic [DistW-1:0]         rd_dist_o,
  output      logic [VertW:0]           rd_hop_o
);
  localparam int unsigned AW = $clog2(NumV);

  logic [DistW-1:0] dist_mem [NumV];
  logic [VertW:0]   hop_mem  [NumV];
  logic [DistW-1:0] dkj_q;
  logic [DistW-1:0] relax_sum;
  logic             relax_we;

  // rd_dist_o holds row wr_row_i while relaxing
  assign relax_sum = sat_add(dik_i, dkj_q);
  assign relax_we  = relax_i && (relax_sum < rd_dist_o);

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      dist_mem[wr_row_i] <= (wr_row_i == AW'(Col)) ? '0 : DistInf;
      hop_mem[wr_row_i]  <= '0;
    end else if (wr_en_i) begin
      // edge load: the hop toward this column is the column itself
      dist_mem[wr_row_i] <= wr_dist_i;
      hop_mem[wr_row_i]  <= {1'b1, VertW'(Col)};
    end else if (relax_we) begin
      dist_mem[wr_row_i] <= relax_sum;
      hop_mem[wr_row_i]  <= hik_i;
    end
    if (kj_load_i) dkj_q <= rd_dist_o;
    rd_dist_o <= dist_mem[rd_row_i];
    rd_hop_o  <= hop_mem[rd_row_i];
  end
endmodule
`default_nettype wire

// ===== rtl/all_pairs_shortest_path_unit.sv =====
`default_nettype none
// Clear: one row of every cell per cycle, no result.
// Add edge: row read, then compare and write of both directions, no result.
// Query: the row is read at the transfer and StQOut registers the result. Solve: for n
//   active vertices, StSK and StSKl latch each pivot row, then one row per cycle is relaxed.
// One item at a time; a waiting result holds off the input.
// Reset: async active low; runs the clear sweep before taking items.
module all_pairs_shortest_path_unit
  import apsp_pkg::*;
#(
  parameter int unsigned NumV = MaxVertices
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [6:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  // opcode[1:0], first_vertex[7:2], second_vertex[13:8], edge_weight[29:14]
  input  wire logic [31:0] s_axis_tdata_i,
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // path_distance[23:0], hop_valid[24], next_hop[30:25]
  output      logic [31:0] m_axis_tdata_o,
  // answer_kind
  output      logic        m_axis_tuser_o
);
  localparam int unsigned AW = $clog2(NumV);
  localparam logic [AW-1:0] LastRow = AW'(NumV - 1);

  localparam logic [3:0] StReset = 4'd0, StIdle = 4'd1, StClear = 4'd2,
                         StAddCmp = 4'd3, StQOut = 4'd4, StSK = 4'd5,
                         StSKl = 4'd6, StSRel = 4'd7, StOut = 4'd8;

  logic [3:0] state_q;
  logic [6:0] vcount_q;
  logic [AW:0] n_eff;
  logic [AW-1:0] a_q, b_q, k_q, i_q;
  logic [WeightW-1:0] w_q;
  logic in_ok_q;
  logic out_valid_q, out_kind_q, out_hv_q;
  logic [DistW-1:0] out_dist_q;
  logic [VertW-1:0] out_hop_q;

  logic [DistW-1:0] cell_dist [NumV];
  logic [VertW:0]   cell_hop  [NumV];
  logic [AW-1:0]    sel_col, rd_row;
  logic [DistW-1:0] sel_dist, w_ext;
  logic [VertW:0]   sel_hop;
  logic clr_on, add_we, kj_load, relax_on;

  always_comb begin
    if (vcount_q == 7'd0) n_eff = (AW+1)'(1);
    else if (32'(vcount_q) > NumV) n_eff = (AW+1)'(NumV);
    else n_eff = (AW+1)'(vcount_q);
  end

  op_e in_op;
  logic [AW-1:0] in_a, in_b;
  assign in_op = op_e'(s_axis_tdata_i[1:0]);
  assign in_a  = AW'(s_axis_tdata_i[7:2]);
  assign in_b  = AW'(s_axis_tdata_i[13:8]);
  logic in_a_ok, in_b_ok;
  assign in_a_ok = 32'(s_axis_tdata_i[7:2]) < 32'(n_eff);
  assign in_b_ok = 32'(s_axis_tdata_i[13:8]) < 32'(n_eff);

  assign s_axis_tready_o = (state_q == StIdle) && !out_valid_q;
  assign cfg_ready_o = 1'b1;
  logic last_i, last_k;
  assign last_i = (AW+1)'(i_q) + 1'b1 == n_eff;
  assign last_k = (AW+1)'(k_q) + 1'b1 == n_eff;

  // pivot column during solve, destination column for add and query
  assign sel_col  = (state_q == StSRel) ? k_q : b_q;
  assign sel_dist = cell_dist[sel_col];
  assign sel_hop  = cell_hop[sel_col];
  assign w_ext    = {{(DistW-WeightW){1'b0}}, w_q};

  assign clr_on   = (state_q == StReset) || (state_q == StClear);
  assign add_we   = (state_q == StAddCmp) && (w_ext < sel_dist);
  assign kj_load  = (state_q == StSKl);
  assign relax_on = (state_q == StSRel);

  always_comb begin
    case (state_q)
      StIdle: rd_row = in_a;
      StSK: rd_row = k_q;
      StSRel: rd_row = i_q + 1'b1;
      default: rd_row = i_q;
    endcase
  end

  for (genvar c = 0; c < NumV; c++) begin : g_cell
    logic hit_a, hit_b;
    assign hit_a = (a_q == AW'(c));
    assign hit_b = (b_q == AW'(c));
    apsp_cell #(
      .NumV(NumV),
      .Col (c)
    ) u_cell (
      .clk_i,
      .clr_i      (clr_on),
      .wr_en_i    (add_we && (hit_a || hit_b)),
      .wr_row_i   ((state_q == StAddCmp) ? (hit_b ? a_q : b_q) : i_q),
      .wr_dist_i  (w_ext),
      .kj_load_i  (kj_load),
      .relax_i    (relax_on && ((AW+1)'(c) < n_eff)),
      .dik_i      (sel_dist),
      .hik_i      (sel_hop),
      .rd_row_i   (rd_row),
      .rd_dist_o  (cell_dist[c]),
      .rd_hop_o   (cell_hop[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StReset; vcount_q <= 7'd64; i_q <= '0; k_q <= '0;
      a_q <= '0; b_q <= '0; w_q <= '0; in_ok_q <= 1'b0;
      out_valid_q <= 1'b0; out_kind_q <= 1'b0; out_hv_q <= 1'b0;
      out_dist_q <= '0; out_hop_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) vcount_q <= cfg_data_i;
      if (out_valid_q && m_axis_tready_i) out_valid_q <= 1'b0;
      case (state_q)
        StReset, StClear: begin
          if (i_q == LastRow) begin
            i_q <= '0; state_q <= StIdle;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        StIdle: if (s_axis_tvalid_i && s_axis_tready_o) begin
          a_q <= in_a; b_q <= in_b; w_q <= s_axis_tdata_i[29:14];
          in_ok_q <= in_a_ok && in_b_ok;
          i_q <= '0; k_q <= '0;
          case (in_op)
            OpClear: state_q <= StClear;
            OpAdd: if (in_a_ok && in_b_ok) state_q <= StAddCmp;
            OpSolve: state_q <= StSK;
            OpQuery: state_q <= StQOut;
            default: state_q <= StIdle;
          endcase
        end
        StAddCmp: state_q <= StIdle;
        StQOut: begin
          out_valid_q <= 1'b1; out_kind_q <= 1'b1;
          out_dist_q <= in_ok_q ? sel_dist : DistInf;
          out_hop_q  <= (in_ok_q && sel_hop[VertW]) ? sel_hop[VertW-1:0] : '0;
          out_hv_q   <= in_ok_q && sel_hop[VertW];
          state_q <= StIdle;
        end
        StSK: state_q <= StSKl;
        StSKl: state_q <= StSRel;
        StSRel: begin
          if (!last_i) i_q <= i_q + 1'b1;
          else begin
            i_q <= '0;
            if (last_k) state_q <= StOut;
            else begin
              k_q <= k_q + 1'b1; state_q <= StSK;
            end
          end
        end
        StOut: begin
          out_valid_q <= 1'b1; out_kind_q <= 1'b0; out_dist_q <= '0;
          out_hv_q <= 1'b0; out_hop_q <= '0; state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = {1'b0, out_hop_q, out_hv_q, out_dist_q};
endmodule
`default_nettype wire

// ===== rtl/apsp_checker.sv =====
`default_nettype none
module apsp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output changed while stalled");
  a_solve_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == 32'd0)
    else $error("solve result not zero");
  a_nohop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[24] |-> m_axis_tdata_o[30:25] == 6'd0)
    else $error("hop without valid");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input taken with result pending");
endmodule
bind all_pairs_shortest_path_unit apsp_checker u_chk (.*);
`default_nettype wire
